// ===== rtl/core/vcpd_pkg.sv =====
// shared types, codes and constants of the video cell pixel decoder
package vcpd_pkg;

  typedef struct packed {
    logic       new_mode_enable;
    logic [1:0] new_screen;
    logic [2:0] color_set;
    logic       four_color;
  } vcpd_cfg_t;

  typedef struct packed {
    logic [13:0]     font_addr;
    logic [3:0]      span;
    logic            short_run;
    logic [7:0][2:0] pal;
    logic [7:0][4:0] idx;
  } vcpd_job_t;

  // configuration register indexes
  localparam logic [1:0] REG_NEW_MODE_ENABLE = 2'd0;
  localparam logic [1:0] REG_NEW_SCREEN      = 2'd1;
  localparam logic [1:0] REG_COLOR_SET       = 2'd2;
  localparam logic [1:0] REG_FOUR_COLOR      = 2'd3;

  // palette selects
  localparam logic [2:0] PAL_MAIN    = 3'd0;
  localparam logic [2:0] PAL_TEXT    = 3'd1;
  localparam logic [2:0] PAL_SEMI    = 3'd2;
  localparam logic [2:0] PAL_COLOR   = 3'd3;
  localparam logic [2:0] PAL_MONO    = 3'd4;
  localparam logic [2:0] PAL_FOUR    = 3'd5;
  localparam logic [2:0] PAL_NEW_GFX = 3'd6;

  // old graphics submodes
  localparam logic [2:0] SUB_TEXT      = 3'd0;
  localparam logic [2:0] SUB_C64_M128  = 3'd1;
  localparam logic [2:0] SUB_C128X64   = 3'd2;
  localparam logic [2:0] SUB_M128X96   = 3'd3;
  localparam logic [2:0] SUB_C128X96   = 3'd4;
  localparam logic [2:0] SUB_M128X192  = 3'd5;
  localparam logic [2:0] SUB_C128_M256 = 3'd6;

  // new screen codes
  localparam logic [1:0] SCREEN_TEXT = 2'd0;
  localparam logic [1:0] SCREEN_FOUR = 2'd1;

  // host pixel spans
  localparam logic [3:0] SPAN_2 = 4'd2;
  localparam logic [3:0] SPAN_4 = 4'd4;
  localparam logic [3:0] SPAN_8 = 4'd8;

  // glyph rom bases
  localparam logic [13:0] FONT_SEMI_BASE  = 14'h1000;
  localparam logic [13:0] FONT_GRAPH_BASE = 14'h2000;

  localparam logic [4:0] IDX_SEMI_BG = 5'd8;

  function automatic logic [2:0] submode_of(input logic [7:0] attr);
    logic [2:0] s;
    s = SUB_TEXT;
    if (attr[7]) begin
      unique case (attr[4:2])
        3'b000, 3'b100: s = SUB_C64_M128;
        3'b010:         s = SUB_C128X64;
        3'b110:         s = SUB_M128X96;
        3'b001:         s = SUB_C128X96;
        3'b101:         s = SUB_M128X192;
        default:        s = SUB_C128_M256;
      endcase
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/vcpd_cfg.sv =====
// apb configuration registers
module vcpd_cfg
  import vcpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output vcpd_cfg_t   cfg
);

  logic       wr;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (reg_idx)
        REG_NEW_MODE_ENABLE: cfg.new_mode_enable <= pwdata[0];
        REG_NEW_SCREEN:      cfg.new_screen      <= pwdata[1:0];
        REG_COLOR_SET:       cfg.color_set       <= pwdata[2:0];
        REG_FOUR_COLOR:      cfg.four_color      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_NEW_MODE_ENABLE: prdata = {31'b0, cfg.new_mode_enable};
      REG_NEW_SCREEN:      prdata = {30'b0, cfg.new_screen};
      REG_COLOR_SET:       prdata = {29'b0, cfg.color_set};
      REG_FOUR_COLOR:      prdata = {31'b0, cfg.four_color};
      default:             prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/vcpd_front.sv =====
// front end: submode latch and cell classification into a pixel job
module vcpd_front
  import vcpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  vcpd_cfg_t  cfg,
  input  logic       frame_start,
  input  logic [7:0] attr_byte,
  input  logic [7:0] data_byte,
  input  logic [7:0] glyph_row,
  input  logic [3:0] row_in_char,
  output vcpd_job_t  job
);

  typedef enum logic [2:0] {
    RUN_GLYPH,
    RUN_PAIR,
    RUN_BIT,
    RUN_NEW4,
    RUN_NEW2
  } run_t;

  logic [2:0]  old_submode;
  logic [2:0]  sub;
  run_t        run;
  logic [13:0] addr;
  logic [13:0] row_ext;
  logic [2:0]  fpal, bpal, gpal;
  logic [4:0]  fidx, bidx, base, cbase;
  logic [3:0]  span, fm_span4, fm_spanm;
  logic        fm;

  always_ff @(posedge clk) begin
    if (rst) begin
      old_submode <= SUB_TEXT;
    end else if (accept && frame_start) begin
      old_submode <= submode_of(attr_byte);
    end
  end

  assign row_ext = {10'b0, row_in_char};
  assign cbase   = {2'b0, attr_byte[1], 2'b0};

  always_comb begin
    sub      = frame_start ? submode_of(attr_byte) : old_submode;
    run      = RUN_GLYPH;
    addr     = '0;
    fpal     = PAL_MAIN;
    bpal     = PAL_MAIN;
    gpal     = PAL_MAIN;
    fidx     = '0;
    bidx     = '0;
    base     = '0;
    span     = SPAN_2;
    fm       = 1'b0;
    fm_span4 = SPAN_8;
    fm_spanm = SPAN_4;
    if (!cfg.new_mode_enable) begin
      if (sub == SUB_TEXT) begin
        run = RUN_GLYPH;
        if (attr_byte[6]) begin
          fpal = PAL_SEMI;
          bpal = PAL_MAIN;
          bidx = IDX_SEMI_BG;
          if (attr_byte[5]) begin
            addr = {4'b0, data_byte[5:0], 4'b0} + FONT_SEMI_BASE + row_ext;
            fidx = {2'b0, attr_byte[1], data_byte[7:6]};
          end else begin
            addr = {6'b0, data_byte[3:0], 4'b0} + FONT_GRAPH_BASE + row_ext;
            fidx = {2'b0, data_byte[6:4]};
          end
        end else begin
          fpal = PAL_TEXT;
          bpal = PAL_TEXT;
          fidx = {3'b0, attr_byte[1:0]};
          bidx = {3'b0, attr_byte[1:0] ^ 2'b01};
          addr = {2'b0, data_byte, 4'b0} + row_ext;
        end
      end else begin
        run  = RUN_PAIR;
        gpal = PAL_COLOR;
        base = cbase;
        unique case (sub)
          SUB_C64_M128: begin
            fm   = attr_byte[4];
            span = SPAN_8;
          end
          SUB_C128X64, SUB_C128X96: begin
            span = SPAN_4;
          end
          SUB_M128X96, SUB_M128X192: begin
            fm = 1'b1;
          end
          default: begin
            fm       = attr_byte[4];
            span     = SPAN_4;
            fm_span4 = SPAN_4;
            fm_spanm = SPAN_2;
          end
        endcase
        if (fm) begin
          if (cfg.four_color) begin
            run  = RUN_PAIR;
            gpal = PAL_FOUR;
            base = cbase;
            span = fm_span4;
          end else begin
            run  = RUN_BIT;
            gpal = PAL_MONO;
            base = {3'b0, attr_byte[1], 1'b0};
            span = fm_spanm;
          end
        end
      end
    end else if (cfg.new_screen == SCREEN_TEXT) begin
      run  = RUN_GLYPH;
      addr = {2'b0, data_byte, 4'b0} + (attr_byte[7] ? FONT_SEMI_BASE : 14'd0) + row_ext;
      fpal = PAL_MAIN;
      bpal = PAL_MAIN;
      fidx = {1'b0, attr_byte[3:0]};
      bidx = {1'b0, cfg.color_set[1], attr_byte[6:4]};
    end else if (cfg.new_screen == SCREEN_FOUR) begin
      run  = RUN_NEW4;
      gpal = PAL_NEW_GFX;
      span = SPAN_4;
    end else begin
      run  = RUN_NEW2;
      gpal = PAL_NEW_GFX;
      span = SPAN_2;
    end
  end

  always_comb begin
    job.font_addr = addr;
    job.span      = span;
    job.short_run = (run == RUN_PAIR) || (run == RUN_NEW4);
    for (int k = 0; k < 8; k++) begin
      job.pal[k] = gpal;
      job.idx[k] = '0;
      unique case (run)
        RUN_GLYPH: begin
          job.pal[k] = glyph_row[7-k] ? fpal : bpal;
          job.idx[k] = glyph_row[7-k] ? fidx : bidx;
        end
        RUN_PAIR: job.idx[k] = base | {3'b0, data_byte[7-2*(k%4) -: 2]};
        RUN_BIT:  job.idx[k] = base | {4'b0, data_byte[7-k]};
        RUN_NEW4: job.idx[k] = {cfg.color_set[2], data_byte[7-2*(k%4) -: 2],
                                attr_byte[7-2*(k%4) -: 2]};
        default:  job.idx[k] = {cfg.color_set, data_byte[7-k], attr_byte[7-k]};
      endcase
    end
  end

endmodule

// ===== rtl/core/vcpd_queue.sv =====
// short job queue between front and back
module vcpd_queue
  import vcpd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  vcpd_job_t push_job,
  input  logic      pop,
  output vcpd_job_t head,
  output logic      full,
  output logic      empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  vcpd_job_t     entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/vcpd_back.sv =====
// back end: serializes a job into pixels through the output register
module vcpd_back
  import vcpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  vcpd_job_t   head,
  input  logic        head_valid,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] font_addr,
  output logic [2:0]  palette_sel,
  output logic [4:0]  color_index,
  output logic [3:0]  pixel_span,
  output logic        last_pixel
);

  logic [2:0] ptr;
  logic       load;
  logic       at_last;

  assign load    = head_valid && (!out_valid || !out_stall);
  assign at_last = head.short_run ? (ptr == 3'd3) : (ptr == 3'd7);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        ptr       <= at_last ? 3'd0 : ptr + 3'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      font_addr   <= head.font_addr;
      palette_sel <= head.pal[ptr];
      color_index <= head.idx[ptr];
      pixel_span  <= head.span;
      last_pixel  <= at_last;
    end
  end

endmodule

// ===== rtl/core/video_cell_pixel_decoder_core.sv =====
// top level of the video cell pixel decoder
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  cell in  | in_valid / in_stall   | frame_start attr_byte data_byte glyph_row row_in_char
//  pixel out| out_valid / out_stall | font_addr palette_sel color_index pixel_span last_pixel
//  config   | psel penable pwrite   | paddr pwdata prdata pready
//
// a text or two-color cell gives 8 pixels at the output, a four-color or pair cell 4;
// the pixel serializer sends one pixel a cycle while out_stall does not hold it
// cells enter one per cycle while the job queue (QUEUE_DEPTH entries) has room
// synchronous active-high reset clears config, submode latch, queue and output valid
// out_stall holds the current pixel; the queue fills and then raises in_stall
module video_cell_pixel_decoder_core
  import vcpd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        frame_start,
  input  logic [7:0]  attr_byte,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  glyph_row,
  input  logic [3:0]  row_in_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] font_addr,
  output logic [2:0]  palette_sel,
  output logic [4:0]  color_index,
  output logic [3:0]  pixel_span,
  output logic        last_pixel,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  vcpd_cfg_t cfg;
  vcpd_job_t job;
  vcpd_job_t head;
  logic      q_push, q_pop, q_full, q_empty;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  vcpd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vcpd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (q_push),
    .cfg         (cfg),
    .frame_start (frame_start),
    .attr_byte   (attr_byte),
    .data_byte   (data_byte),
    .glyph_row   (glyph_row),
    .row_in_char (row_in_char),
    .job         (job)
  );

  vcpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (job),
    .pop      (q_pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  vcpd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (!q_empty),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .font_addr   (font_addr),
    .palette_sel (palette_sel),
    .color_index (color_index),
    .pixel_span  (pixel_span),
    .last_pixel  (last_pixel)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("job queue popped while empty");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_span_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_span == SPAN_2 || pixel_span == SPAN_4 || pixel_span == SPAN_8))
    else $error("illegal pixel span");

  a_pal_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (palette_sel <= PAL_NEW_GFX))
    else $error("illegal palette select");

endmodule

// ===== sim/cell_pixel_checker.sv =====
// checker that predicts the pixel run of every accepted cell and compares the pixel outputs
`timescale 1ns / 1ps
module cell_pixel_checker
  import vcpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        frame_start,
  input  logic [7:0]  attr_byte,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  glyph_row,
  input  logic [3:0]  row_in_char,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [13:0] font_addr,
  input  logic [2:0]  palette_sel,
  input  logic [4:0]  color_index,
  input  logic [3:0]  pixel_span,
  input  logic        last_pixel,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatch_count,
  output int          pixels_pending
);

  typedef struct {
    logic [13:0] font_addr;
    logic [2:0]  pal;
    logic [4:0]  idx;
    logic [3:0]  span;
    logic        last;
  } pixel_t;

  pixel_t     expected_pixels[$];
  vcpd_cfg_t  cfg;
  logic [2:0] submode;

  function automatic logic [2:0] latch_submode(input logic [7:0] attr);
    logic [2:0] s;
    s = SUB_TEXT;
    if (attr[7]) begin
      case (attr[4:2])
        3'b000, 3'b100: s = SUB_C64_M128;
        3'b010:         s = SUB_C128X64;
        3'b110:         s = SUB_M128X96;
        3'b001:         s = SUB_C128X96;
        3'b101:         s = SUB_M128X192;
        default:        s = SUB_C128_M256;
      endcase
    end
    return s;
  endfunction

  task automatic push_pixel(input logic [13:0] addr, input logic [2:0] pal,
                            input logic [4:0] idx, input logic [3:0] span, input logic last);
    pixel_t p;
    p.font_addr = addr;
    p.pal = pal;
    p.idx = idx;
    p.span = span;
    p.last = last;
    expected_pixels.push_back(p);
  endtask

  task automatic push_glyph(input logic [13:0] addr, input logic [7:0] bits,
                            input logic [2:0] fpal, input logic [4:0] fidx,
                            input logic [2:0] bpal, input logic [4:0] bidx);
    for (int k = 0; k < 8; k++) begin
      if (bits[7 - k]) push_pixel(addr, fpal, fidx, SPAN_2, k == 7);
      else push_pixel(addr, bpal, bidx, SPAN_2, k == 7);
    end
  endtask

  task automatic push_pairs(input logic [7:0] data, input logic [2:0] pal,
                            input logic [4:0] base, input logic [3:0] span);
    for (int k = 0; k < 4; k++)
      push_pixel(14'h0, pal, base | {3'b0, data[7 - 2 * k -: 2]}, span, k == 3);
  endtask

  task automatic push_bits(input logic [7:0] data, input logic [2:0] pal,
                           input logic [4:0] base, input logic [3:0] span);
    for (int k = 0; k < 8; k++)
      push_pixel(14'h0, pal, base | {4'b0, data[7 - k]}, span, k == 7);
  endtask

  // old graphics: four-color pairs or mono bits
  task automatic push_four_mono(input logic [7:0] attr, input logic [7:0] data,
                                input logic [3:0] span_four, input logic [3:0] span_mono);
    if (cfg.four_color) push_pairs(data, PAL_FOUR, {2'b0, attr[1], 2'b0}, span_four);
    else push_bits(data, PAL_MONO, {3'b0, attr[1], 1'b0}, span_mono);
  endtask

  task automatic decode_cell(input logic fs, input logic [7:0] attr, input logic [7:0] data,
                             input logic [7:0] glyph, input logic [3:0] row);
    logic [4:0] cbase;
    cbase = {2'b0, attr[1], 2'b0};
    if (fs) submode = latch_submode(attr);
    if (!cfg.new_mode_enable) begin
      if (submode == SUB_TEXT) begin
        if (attr[6] && attr[5])
          push_glyph({4'b0, data[5:0], 4'b0} + FONT_SEMI_BASE + {10'b0, row}, glyph,
                     PAL_SEMI, {2'b0, attr[1], data[7:6]}, PAL_MAIN, IDX_SEMI_BG);
        else if (attr[6])
          push_glyph({6'b0, data[3:0], 4'b0} + FONT_GRAPH_BASE + {10'b0, row}, glyph,
                     PAL_SEMI, {2'b0, data[6:4]}, PAL_MAIN, IDX_SEMI_BG);
        else
          push_glyph({2'b0, data, 4'b0} + {10'b0, row}, glyph,
                     PAL_TEXT, {3'b0, attr[1:0]}, PAL_TEXT, {3'b0, attr[1], ~attr[0]});
      end else begin
        case (submode)
          SUB_C64_M128: begin
            if (attr[4]) push_four_mono(attr, data, SPAN_8, SPAN_4);
            else push_pairs(data, PAL_COLOR, cbase, SPAN_8);
          end
          SUB_C128X64, SUB_C128X96: push_pairs(data, PAL_COLOR, cbase, SPAN_4);
          SUB_M128X96, SUB_M128X192: push_four_mono(attr, data, SPAN_8, SPAN_4);
          default: begin
            if (attr[4]) push_four_mono(attr, data, SPAN_4, SPAN_2);
            else push_pairs(data, PAL_COLOR, cbase, SPAN_4);
          end
        endcase
      end
    end else if (cfg.new_screen == SCREEN_TEXT) begin
      push_glyph({2'b0, data, 4'b0} + (attr[7] ? FONT_SEMI_BASE : 14'h0) + {10'b0, row},
                 glyph, PAL_MAIN, {1'b0, attr[3:0]}, PAL_MAIN,
                 {1'b0, cfg.color_set[1], attr[6:4]});
    end else if (cfg.new_screen == SCREEN_FOUR) begin
      for (int k = 0; k < 4; k++)
        push_pixel(14'h0, PAL_NEW_GFX,
                   {cfg.color_set[2], data[7 - 2 * k -: 2], attr[7 - 2 * k -: 2]},
                   SPAN_4, k == 3);
    end else begin
      // two-color graphics, unused screen code included
      for (int k = 0; k < 8; k++)
        push_pixel(14'h0, PAL_NEW_GFX, {cfg.color_set, data[7 - k], attr[7 - k]},
                   SPAN_2, k == 7);
    end
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    case (index)
      REG_NEW_MODE_ENABLE: cfg.new_mode_enable = value[0];
      REG_NEW_SCREEN:      cfg.new_screen = value[1:0];
      REG_COLOR_SET:       cfg.color_set = value[2:0];
      REG_FOUR_COLOR:      cfg.four_color = value[0];
      default: ;
    endcase
  endtask

  task automatic report_field(input string field, input logic [13:0] want,
                              input logic [13:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 200)
        $error("%s expected %0h actual %0h", field, want, got);
    end
  endtask

  task automatic check_pixel();
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 200)
        $error("pixel transaction with no expected pixel, font_addr %0h", font_addr);
    end else begin
      want = expected_pixels.pop_front();
      report_field("font_addr", want.font_addr, font_addr);
      report_field("palette_sel", 14'(want.pal), 14'(palette_sel));
      report_field("color_index", 14'(want.idx), 14'(color_index));
      report_field("pixel_span", 14'(want.span), 14'(pixel_span));
      report_field("last_pixel", 14'(want.last), 14'(last_pixel));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg = '0;
      submode = SUB_TEXT;
      expected_pixels.delete();
      mismatch_count = 0;
      pixels_pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) write_reg(paddr[3:2], pwdata);
      if (in_valid && !in_stall)
        decode_cell(frame_start, attr_byte, data_byte, glyph_row, row_in_char);
      if (out_valid && !out_stall) check_pixel();
      pixels_pending = expected_pixels.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
// testbench top: clock, reset, cell and register stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module testbench;
  import vcpd_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        frame_start;
  logic [7:0]  attr_byte;
  logic [7:0]  data_byte;
  logic [7:0]  glyph_row;
  logic [3:0]  row_in_char;
  logic        out_valid;
  logic        out_stall;
  logic [13:0] font_addr;
  logic [2:0]  palette_sel;
  logic [4:0]  color_index;
  logic [3:0]  pixel_span;
  logic        last_pixel;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int pixels_pending;
  int burst_left;
  bit gaps_on;
  bit hold_request;

  video_cell_pixel_decoder_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .frame_start(frame_start), .attr_byte(attr_byte), .data_byte(data_byte),
    .glyph_row(glyph_row), .row_in_char(row_in_char),
    .out_valid(out_valid), .out_stall(out_stall),
    .font_addr(font_addr), .palette_sel(palette_sel), .color_index(color_index),
    .pixel_span(pixel_span), .last_pixel(last_pixel),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cell_pixel_checker pixel_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .frame_start(frame_start), .attr_byte(attr_byte), .data_byte(data_byte),
    .glyph_row(glyph_row), .row_in_char(row_in_char),
    .out_valid(out_valid), .out_stall(out_stall),
    .font_addr(font_addr), .palette_sel(palette_sel), .color_index(color_index),
    .pixel_span(pixel_span), .last_pixel(last_pixel),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatch_count(mismatch_count), .pixels_pending(pixels_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin : receiver
    int cyc;
    int hold_left;
    bit hold_done;
    out_stall = 1'b0;
    cyc = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else begin
        case ((cyc / 64) % 4)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 2) == 0);
          2: out_stall = ($urandom_range(0, 2) != 0);
          default: out_stall = (cyc % 5 == 0);
        endcase
      end
    end
  end

  task automatic send_cell(input bit fs, input logic [7:0] attr, input logic [7:0] data,
                           input logic [7:0] glyph, input logic [3:0] row);
    int gap;
    frame_start = fs;
    attr_byte = attr;
    data_byte = data;
    glyph_row = glyph;
    row_in_char = row;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_random_cell();
    bit fs;
    logic [3:0] row;
    fs = ($urandom_range(0, 5) == 0);
    if ($urandom_range(0, 7) == 0) row = 4'($urandom_range(12, 15));
    else row = 4'($urandom_range(0, 11));
    send_cell(fs, 8'($urandom), 8'($urandom), 8'($urandom), row);
  endtask

  task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {index, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pixels_pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic set_config(input logic nme, input logic [1:0] screen,
                            input logic [2:0] cset, input logic four);
    wait_idle();
    apb_write(REG_NEW_MODE_ENABLE, {31'b0, nme});
    apb_write(REG_NEW_SCREEN, {30'b0, screen});
    apb_write(REG_COLOR_SET, {29'b0, cset});
    apb_write(REG_FOUR_COLOR, {31'b0, four});
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    frame_start = 1'b0;
    attr_byte = 8'h00;
    data_byte = 8'h00;
    glyph_row = 8'h00;
    row_in_char = 4'h0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 4'h0;
    pwdata = 32'h0;
    hold_request = 1'b0;
    burst_left = 0;
    gaps_on = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // old text, semigraphics and every old graphics submode
    send_cell(1'b0, 8'h00, 8'h00, 8'h00, 4'd0);
    send_cell(1'b0, 8'h03, 8'hff, 8'hff, 4'd15);
    send_cell(1'b0, 8'h40, 8'hff, 8'ha5, 4'd11);
    send_cell(1'b0, 8'h62, 8'hff, 8'h5a, 4'd13);
    send_cell(1'b1, 8'h80, 8'he4, 8'h00, 4'd0);
    send_cell(1'b1, 8'h90, 8'h96, 8'hff, 4'd1);
    send_cell(1'b1, 8'h8a, 8'h1b, 8'h00, 4'd2);
    send_cell(1'b1, 8'h98, 8'hc3, 8'h00, 4'd3);
    send_cell(1'b1, 8'h84, 8'h3c, 8'h00, 4'd4);
    send_cell(1'b1, 8'h96, 8'h81, 8'h00, 4'd5);
    send_cell(1'b1, 8'h8c, 8'hff, 8'h00, 4'd6);
    send_cell(1'b1, 8'h9e, 8'h7e, 8'h00, 4'd7);
    send_cell(1'b0, 8'h00, 8'h55, 8'h00, 4'd8);
    set_config(1'b0, 2'd0, 3'd0, 1'b1);
    send_cell(1'b1, 8'h90, 8'he4, 8'h00, 4'd0);
    send_cell(1'b1, 8'hbe, 8'h1b, 8'h00, 4'd0);
    send_cell(1'b1, 8'h9a, 8'hd2, 8'h00, 4'd0);
    // new text, latch while in new modes
    set_config(1'b1, SCREEN_TEXT, 3'd7, 1'b0);
    send_cell(1'b0, 8'h7f, 8'hff, 8'h81, 4'd9);
    send_cell(1'b1, 8'h80, 8'h00, 8'h7e, 4'd0);
    send_cell(1'b1, 8'h00, 8'h41, 8'hf0, 4'd3);
    set_config(1'b1, SCREEN_FOUR, 3'd4, 1'b0);
    send_cell(1'b0, 8'he4, 8'h1b, 8'h00, 4'd0);
    set_config(1'b1, 2'd2, 3'd0, 1'b0);
    send_cell(1'b0, 8'hff, 8'h00, 8'h00, 4'd0);
    // unused screen code
    set_config(1'b1, 2'd3, 3'd7, 1'b1);
    send_cell(1'b0, 8'h0f, 8'hf0, 8'h00, 4'd0);
    set_config(1'b0, 2'd0, 3'd0, 1'b0);
    send_cell(1'b0, 8'h41, 8'h3a, 8'hc6, 4'd10);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_config(1'b0, 2'd0, 3'd0, 1'b0);
        1: set_config(1'b1, 2'd3, 3'd7, 1'b1);
        2: set_config(1'b0, 2'd0, 3'd7, 1'b1);
        3: set_config(1'b1, SCREEN_TEXT, 3'd2, 1'b0);
        4: set_config(1'b1, SCREEN_FOUR, 3'd5, 1'b0);
        default: set_config(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                            3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      endcase
      gaps_on = (phase % 3 != 2);
      if (phase == 2) hold_request = 1'b1;
      for (int n = 0; n < 18; n++) send_random_cell();
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/vcpd_pkg.sv
rtl/core/vcpd_cfg.sv
rtl/core/vcpd_front.sv
rtl/core/vcpd_queue.sv
rtl/core/vcpd_back.sv
rtl/core/video_cell_pixel_decoder_core.sv
sim/cell_pixel_checker.sv
sim/testbench.sv
